// ===== design/iir_filter_direct_form_one_defines.svh =====
// Assertion macros shared by the IIR filter RTL.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef IIR_FILTER_DIRECT_FORM_ONE_DEFINES_SVH
`define IIR_FILTER_DIRECT_FORM_ONE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define IIR_DFO_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define IIR_DFO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/iir_dfo_pkg.sv =====
// Shared types and constants for the direct-form-I IIR filter.
// No dependencies; used by every module of the block.
package iir_dfo_pkg;

    localparam int CHANNELS   = 2;
    localparam int ORDER      = 3;
    localparam int CHAN_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 32;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int ACC_W    = PROD_W + $clog2(2 * ORDER + 1);
    localparam int FRAC_SHIFT = 24;           // Q9.47 -> Q1.23

    localparam int SAMPLE_MAX = 8388607;
    localparam int SAMPLE_MIN = -8388608;

    localparam int COEF_TAPS = 4;             // b0..b3, a1..a3 always stored
    localparam logic [COEF_W-1:0] COEF_B0_RESET = 32'h0100_0000;  // 1.0

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_B3 = 3'd3,
        REG_A1 = 3'd4,
        REG_A2 = 3'd5,
        REG_A3 = 3'd6
    } cfg_reg_e;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // b[k] weights x[n-k]; a[k-1] weights y[n-k]
    typedef struct packed {
        logic [COEF_TAPS-1:0][COEF_W-1:0]   b;
        logic [COEF_TAPS-2:0][COEF_W-1:0]   a;
    } coef_set_t;

    // newest sample at index 0
    typedef logic [ORDER-1:0][SAMPLE_W-1:0] hist_t;

    typedef struct packed {
        logic                  en;
        logic [CHAN_IDX_W-1:0] idx;
    } hist_wr_t;

endpackage

// ===== design/iir_dfo_coef_regs.sv =====
// Coefficient register file written through the configuration port.
// Depends on iir_dfo_pkg.
module iir_dfo_coef_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [iir_dfo_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [iir_dfo_pkg::COEF_W-1:0]      cfg_data,
    output iir_dfo_pkg::coef_set_t              coefs
);

    iir_dfo_pkg::coef_set_t coefs_reg;
    iir_dfo_pkg::coef_set_t coefs_next;

    always_comb
    begin
        coefs_next = coefs_reg;
        if (cfg_we)
        begin
            unique case (iir_dfo_pkg::cfg_reg_e'(cfg_index))
                iir_dfo_pkg::REG_B0: coefs_next.b[0] = cfg_data;
                iir_dfo_pkg::REG_B1: coefs_next.b[1] = cfg_data;
                iir_dfo_pkg::REG_B2: coefs_next.b[2] = cfg_data;
                iir_dfo_pkg::REG_B3: coefs_next.b[3] = cfg_data;
                iir_dfo_pkg::REG_A1: coefs_next.a[0] = cfg_data;
                iir_dfo_pkg::REG_A2: coefs_next.a[1] = cfg_data;
                iir_dfo_pkg::REG_A3: coefs_next.a[2] = cfg_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // b0 = 1.0, every other tap zero
            coefs_reg <= '{
                b: {{((iir_dfo_pkg::COEF_TAPS - 1) * iir_dfo_pkg::COEF_W){1'b0}},
                    iir_dfo_pkg::COEF_B0_RESET},
                a: '0
            };
        end
        else
        begin
            coefs_reg <= coefs_next;
        end
    end

    assign coefs = coefs_reg;

endmodule

// ===== design/iir_dfo_history.sv =====
// Per-channel input and output delay lines of the filter.
// Depends on iir_dfo_pkg.
module iir_dfo_history
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic [iir_dfo_pkg::CHAN_IDX_W-1:0]      rd_idx,
    output iir_dfo_pkg::hist_t                      x_hist,
    output iir_dfo_pkg::hist_t                      y_hist,
    input  iir_dfo_pkg::hist_wr_t                   wr,
    input  iir_dfo_pkg::sample_t                    wr_x,
    input  iir_dfo_pkg::sample_t                    wr_y
);

    iir_dfo_pkg::hist_t x_hist_reg [iir_dfo_pkg::CHANNELS];
    iir_dfo_pkg::hist_t y_hist_reg [iir_dfo_pkg::CHANNELS];
    iir_dfo_pkg::hist_t x_line_next;
    iir_dfo_pkg::hist_t y_line_next;

    assign x_hist = x_hist_reg[rd_idx];
    assign y_hist = y_hist_reg[rd_idx];

    // shifted line of the channel being written
    always_comb
    begin
        x_line_next = x_hist_reg[wr.idx];
        y_line_next = y_hist_reg[wr.idx];
        for (int k = iir_dfo_pkg::ORDER - 1; k > 0; k--)
        begin
            x_line_next[k] = x_hist_reg[wr.idx][k-1];
            y_line_next[k] = y_hist_reg[wr.idx][k-1];
        end
        x_line_next[0] = wr_x;
        y_line_next[0] = wr_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < iir_dfo_pkg::CHANNELS; c++)
            begin
                x_hist_reg[c] <= '0;
                y_hist_reg[c] <= '0;
            end
        end
        else if (wr.en)
        begin
            x_hist_reg[wr.idx] <= x_line_next;
            y_hist_reg[wr.idx] <= y_line_next;
        end
    end

endmodule

// ===== design/iir_dfo_datapath.sv =====
// Multiply-accumulate, rounding and saturation for one sample.
// Purely combinational; depends on iir_dfo_pkg.
module iir_dfo_datapath
(
    input  iir_dfo_pkg::sample_t        x,
    input  iir_dfo_pkg::hist_t          x_hist,
    input  iir_dfo_pkg::hist_t          y_hist,
    input  iir_dfo_pkg::coef_set_t      coefs,
    output iir_dfo_pkg::sample_t        y
);

    localparam int RES_W = iir_dfo_pkg::ACC_W - iir_dfo_pkg::FRAC_SHIFT;

    logic signed [iir_dfo_pkg::PROD_W-1:0] ff_prod [iir_dfo_pkg::ORDER+1];
    logic signed [iir_dfo_pkg::PROD_W-1:0] fb_prod [iir_dfo_pkg::ORDER];
    logic signed [iir_dfo_pkg::ACC_W-1:0]  acc;
    logic signed [iir_dfo_pkg::ACC_W-1:0]  acc_rnd;
    logic signed [RES_W-1:0]               y_wide;

    // independent products, Q1.23 x Q8.24 = Q9.47
    always_comb
    begin
        ff_prod[0] = $signed(coefs.b[0]) * x;
        for (int k = 1; k <= iir_dfo_pkg::ORDER; k++)
        begin
            ff_prod[k]   = $signed(coefs.b[k]) * $signed(x_hist[k-1]);
            fb_prod[k-1] = $signed(coefs.a[k-1]) * $signed(y_hist[k-1]);
        end
    end

    always_comb
    begin
        acc = iir_dfo_pkg::ACC_W'(ff_prod[0]);
        for (int k = 1; k <= iir_dfo_pkg::ORDER; k++)
        begin
            acc = acc + iir_dfo_pkg::ACC_W'(ff_prod[k])
                      - iir_dfo_pkg::ACC_W'(fb_prod[k-1]);
        end
    end

    // half an LSB up, then floor: halves go toward plus infinity
    assign acc_rnd = acc + (iir_dfo_pkg::ACC_W'(1) << (iir_dfo_pkg::FRAC_SHIFT - 1));
    assign y_wide  = acc_rnd[iir_dfo_pkg::ACC_W-1:iir_dfo_pkg::FRAC_SHIFT];

    always_comb
    begin
        if (y_wide > RES_W'(iir_dfo_pkg::SAMPLE_MAX))
            y = iir_dfo_pkg::SAMPLE_W'(iir_dfo_pkg::SAMPLE_MAX);
        else if (y_wide < RES_W'(iir_dfo_pkg::SAMPLE_MIN))
            y = iir_dfo_pkg::SAMPLE_W'(iir_dfo_pkg::SAMPLE_MIN);
        else
            y = y_wide[iir_dfo_pkg::SAMPLE_W-1:0];
    end

endmodule

// ===== design/iir_filter_direct_form_one.sv =====
// Top level of the direct-form-I IIR filter: input and result registers,
// handshake control. Depends on iir_dfo_pkg, the defines header and the
// coef_regs, history and datapath modules.
//
// Multi-channel direct-form-I IIR filter. Each beat carries a Q1.23 sample
// and a channel number; the block returns y = sum b[k]x[n-k] - sum a[k]y[n-k]
// for that channel, rounded half-up to Q1.23 and saturated, with chan and
// block_end copied alongside. Coefficients are Q8.24 and already divided by
// a0; taps beyond the build-time order are stored but ignored. One beat is
// taken per clock and one result leaves per clock while the output is not
// stalled: a sample sits in the input register after the edge that
// accepts it, and its result enters the output register, raising
// out_valid, once that register is free or being emptied. A stalled
// output holds both registers and drops in_ready. The filter arithmetic
// is combinational between the input and output registers because the
// next sample of the same channel needs this output in its own feedback;
// the clock period is therefore set by the seven parallel 24x32
// multipliers, the adder tree, rounding and saturation. Histories reset to
// zero and are held in flip-flops, so no clearing pass is needed.
// Coefficients may only be written while the filter is empty.
module iir_filter_direct_form_one
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [iir_dfo_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [iir_dfo_pkg::COEF_W-1:0]      cfg_data,
    // sample input
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                chan,
    input  logic signed [23:0]                  sample_in,
    input  logic                                block_end,
    // filtered output
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                chan_out,
    output logic signed [23:0]                  sample_out,
    output logic                                block_end_out
);

`include "iir_filter_direct_form_one_defines.svh"

    // input register
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic                   s1_chan_reg;
    iir_dfo_pkg::sample_t   s1_sample_reg;
    logic                   s1_block_end_reg;

    // result register
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   chan_out_reg;
    iir_dfo_pkg::sample_t   sample_out_reg;
    logic                   block_end_out_reg;

    logic                   in_fire;
    logic                   advance;
    logic [iir_dfo_pkg::CHAN_IDX_W-1:0] s1_idx;

    iir_dfo_pkg::coef_set_t coefs;
    iir_dfo_pkg::hist_t     x_hist;
    iir_dfo_pkg::hist_t     y_hist;
    iir_dfo_pkg::hist_wr_t  hist_wr;
    iir_dfo_pkg::sample_t   y;

    // The input-register sample moves on whenever the result register is
    // free or being emptied; history is written on that same edge, so the
    // next beat of the same channel sees the fresh output.
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    // out-of-range channel numbers share the top channel's history
    assign s1_idx = (32'(s1_chan_reg) >= iir_dfo_pkg::CHANNELS)
                  ? iir_dfo_pkg::CHAN_IDX_W'(iir_dfo_pkg::CHANNELS - 1)
                  : iir_dfo_pkg::CHAN_IDX_W'(s1_chan_reg);

    assign hist_wr.en  = advance;
    assign hist_wr.idx = s1_idx;

    iir_dfo_coef_regs u_coef_regs
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .coefs      (coefs)
    );

    iir_dfo_history u_history
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_idx     (s1_idx),
        .x_hist     (x_hist),
        .y_hist     (y_hist),
        .wr         (hist_wr),
        .wr_x       (s1_sample_reg),
        .wr_y       (y)
    );

    iir_dfo_datapath u_datapath
    (
        .x          (s1_sample_reg),
        .x_hist     (x_hist),
        .y_hist     (y_hist),
        .coefs      (coefs),
        .y          (y)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_chan_reg      <= chan;
            s1_sample_reg    <= sample_in;
            s1_block_end_reg <= block_end;
        end
        if (advance)
        begin
            chan_out_reg      <= s1_chan_reg;
            sample_out_reg    <= y;
            block_end_out_reg <= s1_block_end_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign chan_out      = chan_out_reg;
    assign sample_out    = sample_out_reg;
    assign block_end_out = block_end_out_reg;

    // a held sample must not be overwritten by a new beat
    `IIR_DFO_ASSERT_NOW(a_no_overwrite, s1_valid_reg && out_valid_reg && !out_ready, !in_ready, "input register overwritten while stalled")

    // a stalled sample keeps its payload
    `IIR_DFO_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !advance, s1_valid_reg && $stable(s1_sample_reg) && $stable(s1_chan_reg), "stalled sample lost or changed")

    // an advancing sample becomes a result with its own tags
    `IIR_DFO_ASSERT_NEXT(a_result_tags, advance, out_valid_reg && chan_out_reg == $past(s1_chan_reg) && block_end_out_reg == $past(s1_block_end_reg), "result tags do not follow sample")

    // an accepted beat lands in the input register
    `IIR_DFO_ASSERT_NEXT(a_accept_load, in_fire, s1_valid_reg && s1_sample_reg == $past(sample_in), "accepted beat not captured")

endmodule
